// ===== sv/mrpt_pkg.sv =====
// shared types and constants for the 64-bit primality tester
package mrpt_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned NBASES = 7;
  localparam int unsigned NPRIMES = 10;

  typedef logic [W-1:0] word_t;

  // command to the modular multiply unit
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } mm_rsp_t;

  function automatic word_t mr_base(input logic [2:0] k);
    word_t v;
    case (k)
      3'd0:    v = 64'd2;
      3'd1:    v = 64'd325;
      3'd2:    v = 64'd9375;
      3'd3:    v = 64'd28178;
      3'd4:    v = 64'd450775;
      3'd5:    v = 64'd9780504;
      3'd6:    v = 64'd1795265022;
      default: v = 64'd2;
    endcase
    return v;
  endfunction

  function automatic word_t trial_prime(input logic [3:0] k);
    word_t v;
    case (k)
      4'd0:    v = 64'd2;
      4'd1:    v = 64'd3;
      4'd2:    v = 64'd5;
      4'd3:    v = 64'd7;
      4'd4:    v = 64'd11;
      4'd5:    v = 64'd13;
      4'd6:    v = 64'd17;
      4'd7:    v = 64'd19;
      4'd8:    v = 64'd23;
      4'd9:    v = 64'd29;
      default: v = 64'd2;
    endcase
    return v;
  endfunction

  // ceil(2^24 / p) for each trial prime
  function automatic logic [23:0] trial_recip(input logic [3:0] k);
    logic [23:0] v;
    case (k)
      4'd0:    v = 24'd8388608;
      4'd1:    v = 24'd5592406;
      4'd2:    v = 24'd3355444;
      4'd3:    v = 24'd2396746;
      4'd4:    v = 24'd1525202;
      4'd5:    v = 24'd1290556;
      4'd6:    v = 24'd986896;
      4'd7:    v = 24'd883012;
      4'd8:    v = 24'd729445;
      4'd9:    v = 24'd578525;
      default: v = 24'd8388608;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/mrpt_mulmod.sv =====
// bit-serial modular multiplier: one double-and-add step per cycle
module mrpt_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  mrpt_pkg::word_t  modulus,
  input  mrpt_pkg::mm_req_t req,
  output mrpt_pkg::mm_rsp_t rsp
);
  import mrpt_pkg::*;

  logic        busy_r;
  logic [5:0]  cnt_r;
  word_t       a_r, b_r, acc_r;
  logic        done_r;

  word_t acc_dbl, acc_add;

  function automatic word_t addm(input word_t x, input word_t y, input word_t m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  always_comb begin
    acc_dbl = addm(acc_r, acc_r, modulus);
    acc_add = b_r[W-1] ? addm(acc_dbl, a_r, modulus) : acc_dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'(W-1));
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_add;
        b_r   <= {b_r[W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(W-1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("mulmod done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("mulmod done without work");
  a_res_lt_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> acc_r < modulus) else $error("mulmod result not reduced");
`endif

endmodule

// ===== sv/mrpt_divrem.sv =====
// small-prime remainder unit: folds in one byte of the dividend per cycle
module mrpt_divrem (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mrpt_pkg::word_t dividend,
  input  logic [3:0]      sel,
  output logic            done,
  output logic [4:0]      rem
);
  import mrpt_pkg::*;

  logic        busy_r, done_r;
  logic [2:0]  cnt_r;
  logic [3:0]  sel_r;
  word_t       num_r;
  logic [4:0]  rem_r;

  word_t       prime_w;
  logic [23:0] recip;
  logic [12:0] fold;
  logic [36:0] prod;
  logic [12:0] quot;
  logic [17:0] back;
  logic [12:0] diff;
  logic [4:0]  rem_nxt;

  // rem*256 + byte stays below 29*256, so the 24-bit reciprocal quotient is exact
  always_comb begin
    prime_w = trial_prime(sel_r);
    recip   = trial_recip(sel_r);
    fold    = {rem_r, num_r[W-1 -: 8]};
    prod    = {24'd0, fold} * {13'd0, recip};
    quot    = prod[36:24];
    back    = {5'd0, quot} * {13'd0, prime_w[4:0]};
    diff    = fold - back[12:0];
    rem_nxt = diff[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd7);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        num_r  <= dividend;
        sel_r  <= sel;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[W-9:0], 8'd0};
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

`ifndef ASSERT_OFF
  a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("remainder done held");
  a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("remainder done without work");
  a_div_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < prime_w[4:0]) else $error("remainder not reduced");
`endif

endmodule

// ===== sv/miller_rabin_prime_test_64.sv =====
// top level: sequencer for trial division and miller-rabin on 64-bit numbers
// Tests one unsigned 64-bit number per item and returns is_prime. Numbers
// below 4 and even numbers go straight to the result. Odd numbers run up
// to ten trial remainders on a byte-at-a-time remainder unit, then up to
// seven bases on one bit-serial modular multiplier: a reduction of the
// base mod n, a square-and-multiply ladder and the closing squarings, at
// most 126 products per base. The multiplier, one double-and-add step per
// cycle, sets the run time of an odd number. The input is not ready while
// an item is at work; the result waits in an output register.
module miller_rabin_prime_test_64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_prime
);
  import mrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIAL, S_TRIAL_W, S_SPLIT, S_BASE, S_BASE_W,
    S_POW, S_POW_W, S_SQR, S_SQR_W, S_DONE
  } state_t;

  state_t      state_r;
  word_t       n_r, d_r, e_r, acc_r, sq_r;
  logic [6:0]  s_r, r_r;
  logic [3:0]  tp_r;
  logic [2:0]  bk_r;
  logic        pow_mul_r;   // 1: acc*sq pending, 0: sq*sq
  logic        out_valid_r, out_is_prime_r;

  logic        dv_start, dv_done;
  logic [4:0]  dv_rem;
  mm_req_t     mm_req;
  mm_rsp_t     mm_rsp;
  word_t       nm1;

  assign nm1 = n_r - 64'd1;

  mrpt_divrem u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(n_r),
    .sel(tp_r), .done(dv_done), .rem(dv_rem)
  );

  mrpt_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .modulus(n_r), .req(mm_req), .rsp(mm_rsp)
  );

  always_comb begin
    dv_start = (state_r == S_TRIAL);
    mm_req.start = (state_r == S_BASE) || (state_r == S_POW) || (state_r == S_SQR);
    mm_req.a     = (state_r == S_POW && pow_mul_r) ? acc_r : sq_r;
    mm_req.b     = sq_r;
    if (state_r == S_SQR) begin
      mm_req.a = acc_r;
      mm_req.b = acc_r;
    end
    // base mod n as 1 * base mod n
    if (state_r == S_BASE) begin
      mm_req.a = 64'd1;
      mm_req.b = mr_base(bk_r);
    end
  end

  assign in_ready     = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            n_r <= in_number;
            tp_r <= '0;
            if (in_number < 64'd4) begin
              out_is_prime_r <= (in_number >= 64'd2);
              state_r <= S_DONE;
            end else if (!in_number[0]) begin
              out_is_prime_r <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_TRIAL;
            end
          end
        end
        S_TRIAL: state_r <= S_TRIAL_W;
        S_TRIAL_W: begin
          if (dv_done) begin
            if (n_r == trial_prime(tp_r)) begin
              out_is_prime_r <= 1'b1;
              state_r <= S_DONE;
            end else if (dv_rem == '0) begin
              out_is_prime_r <= 1'b0;
              state_r <= S_DONE;
            end else if (tp_r == 4'(NPRIMES-1)) begin
              d_r <= nm1;
              s_r <= '0;
              state_r <= S_SPLIT;
            end else begin
              tp_r <= tp_r + 4'd1;
              state_r <= S_TRIAL;
            end
          end
        end
        // strip factors of two from n-1, one per cycle
        S_SPLIT: begin
          if (d_r[0]) begin
            bk_r <= '0;
            state_r <= S_BASE;
          end else begin
            d_r <= {1'b0, d_r[W-1:1]};
            s_r <= s_r + 7'd1;
          end
        end
        S_BASE: state_r <= S_BASE_W;
        S_BASE_W: begin
          if (mm_rsp.done) begin
            if (mm_rsp.res == '0) begin
              if (bk_r == 3'(NBASES-1)) begin
                out_is_prime_r <= 1'b1;
                state_r <= S_DONE;
              end else begin
                bk_r <= bk_r + 3'd1;
                state_r <= S_BASE;
              end
            end else begin
              sq_r <= mm_rsp.res;
              acc_r <= 64'd1;
              e_r <= d_r;
              pow_mul_r <= d_r[0];
              state_r <= S_POW;
            end
          end
        end
        S_POW: state_r <= S_POW_W;
        S_POW_W: begin
          if (mm_rsp.done) begin
            if (pow_mul_r) begin
              acc_r <= mm_rsp.res;
              pow_mul_r <= 1'b0;
              // ladder finished
              if (e_r[W-1:1] == '0) begin
                if (mm_rsp.res == 64'd1 || mm_rsp.res == nm1) begin
                  if (bk_r == 3'(NBASES-1)) begin
                    out_is_prime_r <= 1'b1;
                    state_r <= S_DONE;
                  end else begin
                    bk_r <= bk_r + 3'd1;
                    state_r <= S_BASE;
                  end
                end else if (s_r <= 7'd1) begin
                  out_is_prime_r <= 1'b0;
                  state_r <= S_DONE;
                end else begin
                  r_r <= 7'd1;
                  state_r <= S_SQR;
                end
              end else begin
                state_r <= S_POW;  // square next
              end
            end else begin
              sq_r <= mm_rsp.res;
              e_r <= {1'b0, e_r[W-1:1]};
              pow_mul_r <= e_r[1];
              state_r <= S_POW;
            end
          end
        end
        S_SQR: state_r <= S_SQR_W;
        S_SQR_W: begin
          if (mm_rsp.done) begin
            acc_r <= mm_rsp.res;
            if (mm_rsp.res == nm1) begin
              if (bk_r == 3'(NBASES-1)) begin
                out_is_prime_r <= 1'b1;
                state_r <= S_DONE;
              end else begin
                bk_r <= bk_r + 3'd1;
                state_r <= S_BASE;
              end
            end else if (r_r + 7'd1 >= s_r) begin
              out_is_prime_r <= 1'b0;
              state_r <= S_DONE;
            end else begin
              r_r <= r_r + 7'd1;
              state_r <= S_SQR;
            end
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime))
    else $error("result dropped while stalled");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while working");
  a_done_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("no result after done");
`endif

endmodule
